### rtl/rbvs_pkg.sv
package rbvs_pkg;

    // Word format of every velocity, force and position: signed Q16.16.
    localparam int WORD_W = 32;
    localparam int DT_W   = 16;

    // Iteration counts of the shared arithmetic units.
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;

    localparam logic [WORD_W-1:0] SMAX = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] SMIN = 32'h8000_0000;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MODE     = 3'd0;
    localparam logic [2:0] CFG_MASS     = 3'd1;
    localparam logic [2:0] CFG_INIT_SPD = 3'd2;
    localparam logic [2:0] CFG_MAX_SPD  = 3'd3;
    localparam logic [2:0] CFG_FRICTION = 3'd4;
    localparam logic [2:0] CFG_GRAVITY  = 3'd5;

    localparam logic MODE_TOP  = 1'b0;
    localparam logic MODE_BELT = 1'b1;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic               self_driven;
        logic               on_ground;
        logic [15:0]        delta_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic               is_moving;
    } t_out;

    typedef struct packed {
        logic               mode;
        logic [30:0]        mass;
        logic [30:0]        initial_speed;
        logic [30:0]        max_speed;
        logic [30:0]        friction;
        logic signed [31:0] gravity;
    } t_cfg;

    // Datapath operations, one per controller step.
    typedef enum logic [5:0] {
        OP_NONE, OP_LOAD, OP_DIVX, OP_DIVY, OP_AX, OP_AY, OP_FM, OP_LSA, OP_LSB,
        OP_VX, OP_VY, OP_MOV0, OP_SQX, OP_SQY, OP_LEN, OP_KSET, OP_FSET, OP_CSET,
        OP_DIVSX, OP_DIVSY, OP_KX, OP_KY, OP_SX, OP_SY, OP_COM0,
        OP_H, OP_V, OP_MOV1, OP_KB, OP_FRB, OP_GRAV, OP_COM1,
        OP_PX, OP_PY, OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic kick_ok;
        logic len_nz;
        logic over_max;
        logic mode;
    } t_stat;

    typedef enum logic [5:0] {
        S_IDLE, S_DIVX, S_DIVY, S_WDIV, S_FM, S_LSA, S_LSB,
        S_VX, S_VY, S_MOV0, S_SQX, S_SQY, S_WSQ, S_KCHK, S_KSET,
        S_SCX, S_SCY, S_LEN2, S_FCHK, S_FSET, S_LEN3, S_CCHK, S_CSET, S_COM0,
        S_H, S_V, S_MOV1, S_KB, S_FRB, S_GRAV, S_COM1,
        S_PX, S_PY, S_OUT
    } t_state;

endpackage

### rtl/rbvs_div.sv
module rbvs_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot
);

    localparam int CNT_W = $clog2(rbvs_pkg::DIV_STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_quo;
    logic [31:0]      r_rem;
    logic [31:0]      r_dvs;

    logic [32:0] w_sh;
    logic [33:0] w_diff;
    logic        w_ge;

    // One restoring step: bring down the next dividend bit and try the divisor.
    always_comb begin
        w_sh   = {r_rem, r_quo[63]};
        w_diff = {1'b0, w_sh} - {2'b00, r_dvs};
        w_ge   = ~w_diff[33];
    end

    // Control: step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(rbvs_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient bits shift in as dividend bits shift out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[62:0], w_ge};
            r_rem <= w_ge ? w_diff[31:0] : w_sh[31:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

### rtl/rbvs_sqrt.sv
module rbvs_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);

    localparam int CNT_W = $clog2(rbvs_pkg::SQRT_STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_rad;
    logic [33:0]      r_rem;
    logic [31:0]      r_root;

    logic [35:0] w_sh;
    logic [35:0] w_trial;
    logic [36:0] w_diff;
    logic        w_ge;

    // One digit step: bring down two radicand bits and try (4 * root + 1).
    always_comb begin
        w_sh    = {r_rem, r_rad[63:62]};
        w_trial = {2'b00, r_root, 2'b01};
        w_diff  = {1'b0, w_sh} - {1'b0, w_trial};
        w_ge    = ~w_diff[36];
    end

    // Control: step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(rbvs_pkg::SQRT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Root, partial remainder and remaining radicand bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= w_ge ? w_diff[33:0] : w_sh[33:0];
            r_root <= {r_root[30:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### rtl/rbvs_dpath.sv
module rbvs_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rbvs_pkg::t_cmd i_cmd,
    input  rbvs_pkg::t_cfg i_cfg,
    input  rbvs_pkg::t_in  i_in_item,
    output rbvs_pkg::t_stat o_stat,
    output rbvs_pkg::t_out o_out_item
);

    // Magnitude of a signed word; the most negative value gives 2^31.
    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    // base +/- mag, saturated to the signed word range (mag stays within 2^32).
    function automatic logic [31:0] sat_add(input logic [31:0] base, input logic neg,
                                            input logic [32:0] mag);
        logic [33:0] b;
        logic [33:0] m;
        logic [33:0] s;
        b = {{2{base[31]}}, base};
        m = {1'b0, mag};
        s = neg ? (b - m) : (b + m);
        if (!s[33] && (s[32:31] != 2'b00)) begin
            return rbvs_pkg::SMAX;
        end else if (s[33] && (s[32:31] != 2'b11)) begin
            return rbvs_pkg::SMIN;
        end
        return s[31:0];
    endfunction

    // Force times 2^16 over mass, given the unsigned quotient of the magnitudes.
    function automatic logic [31:0] acc_res(input logic [31:0] f, input logic [63:0] q,
                                            input logic mass0);
        if (mass0) begin
            if (f == '0) begin
                return '0;
            end
            return f[31] ? rbvs_pkg::SMIN : rbvs_pkg::SMAX;
        end
        if (f[31]) begin
            return (q > 64'h8000_0000) ? rbvs_pkg::SMIN : (~q[31:0] + 32'd1);
        end
        return (q > 64'h7fff_ffff) ? rbvs_pkg::SMAX : q[31:0];
    endfunction

    // Captured item
    logic [31:0] r_fx, r_fy, r_px, r_py;
    logic        r_self, r_ground;
    logic [15:0] r_dt;
    // Working values
    logic [31:0] r_ax, r_ay, r_vx, r_vy, r_len, r_s, r_npx, r_npy;
    logic [63:0] r_tmp;
    logic [47:0] r_loss;
    logic        r_mnow;
    // Block state
    logic [31:0] r_vel_x, r_vel_y, r_horiz, r_vert;
    logic        r_moving;
    rbvs_pkg::t_out r_out;

    logic [31:0] n_fx, n_fy, n_px, n_py;
    logic        n_self, n_ground;
    logic [15:0] n_dt;
    logic [31:0] n_ax, n_ay, n_vx, n_vy, n_len, n_s, n_npx, n_npy;
    logic [63:0] n_tmp;
    logic [47:0] n_loss;
    logic        n_mnow;
    logic [31:0] n_vel_x, n_vel_y, n_horiz, n_vert;
    logic        n_moving;
    rbvs_pkg::t_out n_out;

    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    logic [32:0] w_tdq;
    logic [62:0] w_lsb;
    logic [31:0] w_sp, w_sp2, w_h;

    logic        w_div_start, w_div_done, w_sqrt_start, w_sqrt_done;
    logic [63:0] w_dividend, w_quot, w_rad;
    logic [31:0] w_divisor, w_root;

    rbvs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    rbvs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_rad   (w_rad),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // Shared multiplier operand selection.
    always_comb begin
        w_ma = '0;
        w_mb = {16'd0, r_dt};
        case (i_cmd.op)
            rbvs_pkg::OP_VX, rbvs_pkg::OP_H: w_ma = mag32(r_ax);
            rbvs_pkg::OP_VY, rbvs_pkg::OP_V: w_ma = mag32(r_ay);
            rbvs_pkg::OP_GRAV:  w_ma = mag32(i_cfg.gravity);
            rbvs_pkg::OP_PX:    w_ma = mag32(r_vel_x);
            rbvs_pkg::OP_PY:    w_ma = mag32(r_vel_y);
            rbvs_pkg::OP_LSA:   w_ma = r_tmp[47:16];
            rbvs_pkg::OP_LSB:   w_ma = {18'd0, r_tmp[61:48]};
            rbvs_pkg::OP_SQX: begin
                w_ma = mag32(r_vx);
                w_mb = mag32(r_vx);
            end
            rbvs_pkg::OP_SQY: begin
                w_ma = mag32(r_vy);
                w_mb = mag32(r_vy);
            end
            rbvs_pkg::OP_FM: begin
                w_ma = {1'b0, i_cfg.friction};
                w_mb = {1'b0, i_cfg.mass};
            end
            rbvs_pkg::OP_DIVSX: begin
                w_ma = mag32(r_vx);
                w_mb = r_s;
            end
            rbvs_pkg::OP_DIVSY: begin
                w_ma = mag32(r_vy);
                w_mb = r_s;
            end
            default: w_ma = '0;
        endcase
        w_prod = w_ma * w_mb;
        // Product with delta_time, back to Q16.16 (truncates the magnitude).
        w_tdq  = {1'b0, w_prod[47:16]};
        w_lsb  = {1'b0, w_prod[29:0], 32'd0} + {15'd0, r_loss};
    end

    // Start of the shared divider and square-root unit.
    always_comb begin
        w_div_start  = 1'b0;
        w_dividend   = w_prod;
        w_divisor    = r_len;
        w_sqrt_start = (i_cmd.op == rbvs_pkg::OP_SQY);
        w_rad        = r_tmp + w_prod;
        case (i_cmd.op)
            rbvs_pkg::OP_DIVX: begin
                w_div_start = 1'b1;
                w_dividend  = {16'd0, mag32(r_fx), 16'd0};
                w_divisor   = {1'b0, i_cfg.mass};
            end
            rbvs_pkg::OP_DIVY: begin
                w_div_start = 1'b1;
                w_dividend  = {16'd0, mag32(r_fy), 16'd0};
                w_divisor   = {1'b0, i_cfg.mass};
            end
            rbvs_pkg::OP_DIVSX, rbvs_pkg::OP_DIVSY: w_div_start = 1'b1;
            default: w_div_start = 1'b0;
        endcase
    end

    // Belt-scroll friction and cap on the horizontal speed.
    always_comb begin
        w_sp  = mag32(r_vx);
        w_sp2 = ({16'd0, w_sp} > r_loss) ? (w_sp - r_loss[31:0]) : '0;
        w_h   = sat_add('0, r_vx[31], {1'b0, w_sp2});
        if ({1'b0, i_cfg.max_speed} < w_sp2) begin
            w_h = sat_add('0, r_vx[31], {2'b00, i_cfg.max_speed});
        end
    end

    // Register updates selected by the current operation.
    always_comb begin
        n_fx = r_fx;  n_fy = r_fy;  n_px = r_px;  n_py = r_py;
        n_self = r_self;  n_ground = r_ground;  n_dt = r_dt;
        n_ax = r_ax;  n_ay = r_ay;  n_vx = r_vx;  n_vy = r_vy;
        n_len = r_len;  n_s = r_s;  n_npx = r_npx;  n_npy = r_npy;
        n_tmp = r_tmp;  n_loss = r_loss;  n_mnow = r_mnow;
        n_vel_x = r_vel_x;  n_vel_y = r_vel_y;  n_horiz = r_horiz;  n_vert = r_vert;
        n_moving = r_moving;  n_out = r_out;
        case (i_cmd.op)
            rbvs_pkg::OP_LOAD: begin
                n_fx     = i_in_item.force_x;
                n_fy     = i_in_item.force_y;
                n_self   = i_in_item.self_driven;
                n_ground = i_in_item.on_ground;
                n_dt     = i_in_item.delta_time;
                n_px     = i_in_item.pos_x;
                n_py     = i_in_item.pos_y;
            end
            rbvs_pkg::OP_AX:  n_ax = acc_res(r_fx, w_quot, i_cfg.mass == '0);
            rbvs_pkg::OP_AY:  n_ay = acc_res(r_fy, w_quot, i_cfg.mass == '0);
            rbvs_pkg::OP_FM:  n_tmp = w_prod;
            rbvs_pkg::OP_LSA: n_loss = w_prod[47:0];
            rbvs_pkg::OP_LSB: n_loss = {1'b0, w_lsb[62:16]};
            rbvs_pkg::OP_VX:  n_vx = sat_add(r_vel_x, r_ax[31], w_tdq);
            rbvs_pkg::OP_VY:  n_vy = sat_add(r_vel_y, r_ay[31], w_tdq);
            rbvs_pkg::OP_H:   n_vx = sat_add(r_horiz, r_ax[31], w_tdq);
            rbvs_pkg::OP_V:   n_vy = sat_add(r_vert, r_ay[31], w_tdq);
            rbvs_pkg::OP_MOV0: begin
                n_mnow = (r_vx != '0) || (r_vy != '0) || (r_fx != '0) || (r_fy != '0);
            end
            rbvs_pkg::OP_MOV1: begin
                n_mnow = (r_vel_x != '0) || (r_vel_y != '0) || (r_fx != '0)
                         || (r_fy != '0);
            end
            rbvs_pkg::OP_SQX: n_tmp = w_prod;
            rbvs_pkg::OP_LEN: n_len = w_root;
            rbvs_pkg::OP_KSET: n_s = {1'b0, i_cfg.initial_speed};
            rbvs_pkg::OP_FSET: begin
                n_s = ({16'd0, r_len} > r_loss) ? (r_len - r_loss[31:0]) : '0;
            end
            rbvs_pkg::OP_CSET: n_s = {1'b0, i_cfg.max_speed};
            rbvs_pkg::OP_KX:  n_vx = sat_add(r_vx, r_vx[31], w_quot[32:0]);
            rbvs_pkg::OP_KY:  n_vy = sat_add(r_vy, r_vy[31], w_quot[32:0]);
            rbvs_pkg::OP_SX:  n_vx = sat_add('0, r_vx[31], w_quot[32:0]);
            rbvs_pkg::OP_SY:  n_vy = sat_add('0, r_vy[31], w_quot[32:0]);
            rbvs_pkg::OP_KB: begin
                if (!r_moving && r_mnow && r_self && (r_vx != '0)) begin
                    n_vx = sat_add(r_vx, r_vx[31], {2'b00, i_cfg.initial_speed});
                end
            end
            rbvs_pkg::OP_FRB: n_vx = w_h;
            rbvs_pkg::OP_GRAV: begin
                if (!r_ground) begin
                    n_vy = sat_add(r_vy, i_cfg.gravity[31], w_tdq);
                end else if (!r_vy[31] && (r_vy != '0)) begin
                    n_vy = '0;
                end
            end
            rbvs_pkg::OP_COM0: begin
                n_vel_x  = r_vx;
                n_vel_y  = r_vy;
                n_moving = r_mnow;
            end
            rbvs_pkg::OP_COM1: begin
                n_vel_x  = r_vx;
                n_vel_y  = r_vy;
                n_horiz  = r_vx;
                n_vert   = r_vy;
                n_moving = r_mnow;
            end
            rbvs_pkg::OP_PX: n_npx = sat_add(r_px, r_vel_x[31], w_tdq);
            rbvs_pkg::OP_PY: n_npy = sat_add(r_py, r_vel_y[31], w_tdq);
            rbvs_pkg::OP_OUT: begin
                n_out.new_pos_x = r_npx;
                n_out.new_pos_y = r_npy;
                n_out.out_vel_x = r_vel_x;
                n_out.out_vel_y = r_vel_y;
                n_out.is_moving = r_moving;
            end
            default: n_mnow = r_mnow;
        endcase
    end

    // State carried from one item to the next.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_x  <= '0;
            r_vel_y  <= '0;
            r_horiz  <= '0;
            r_vert   <= '0;
            r_moving <= 1'b0;
        end else begin
            r_vel_x  <= n_vel_x;
            r_vel_y  <= n_vel_y;
            r_horiz  <= n_horiz;
            r_vert   <= n_vert;
            r_moving <= n_moving;
        end
    end

    // Working registers and the output item.
    always_ff @(posedge i_clk) begin
        r_fx <= n_fx;  r_fy <= n_fy;  r_px <= n_px;  r_py <= n_py;
        r_self <= n_self;  r_ground <= n_ground;  r_dt <= n_dt;
        r_ax <= n_ax;  r_ay <= n_ay;  r_vx <= n_vx;  r_vy <= n_vy;
        r_len <= n_len;  r_s <= n_s;  r_npx <= n_npx;  r_npy <= n_npy;
        r_tmp <= n_tmp;  r_loss <= n_loss;  r_mnow <= n_mnow;
        r_out <= n_out;
    end

    // Status towards the controller.
    always_comb begin
        o_stat.div_done  = w_div_done;
        o_stat.sqrt_done = w_sqrt_done;
        o_stat.kick_ok   = !r_moving && r_mnow && r_self && (r_len != '0);
        o_stat.len_nz    = (r_len != '0);
        o_stat.over_max  = ({1'b0, i_cfg.max_speed} < r_len);
        o_stat.mode      = i_cfg.mode;
    end

    assign o_out_item = r_out;

endmodule

### rtl/rbvs_ctrl.sv
module rbvs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  rbvs_pkg::t_stat i_stat,
    output rbvs_pkg::t_cmd  o_cmd
);

    rbvs_pkg::t_state r_state, n_state;
    rbvs_pkg::t_state r_ret, n_ret;
    rbvs_pkg::t_state r_sret, n_sret;
    rbvs_pkg::t_op    r_wop, n_wop;
    logic             r_kick, n_kick;
    logic             r_out_valid, n_out_valid;

    // State register, return points of the shared sequences and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbvs_pkg::S_IDLE;
            r_ret       <= rbvs_pkg::S_IDLE;
            r_sret      <= rbvs_pkg::S_IDLE;
            r_wop       <= rbvs_pkg::OP_NONE;
            r_kick      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_sret      <= n_sret;
            r_wop       <= n_wop;
            r_kick      <= n_kick;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath command.
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_sret      = r_sret;
        n_wop       = r_wop;
        n_kick      = r_kick;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = rbvs_pkg::OP_NONE;
        o_in_ready  = 1'b0;
        case (r_state)
            rbvs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = rbvs_pkg::OP_LOAD;
                    n_state  = rbvs_pkg::S_DIVX;
                end
            end
            rbvs_pkg::S_DIVX: begin
                o_cmd.op = rbvs_pkg::OP_DIVX;
                n_wop    = rbvs_pkg::OP_AX;
                n_ret    = rbvs_pkg::S_DIVY;
                n_state  = rbvs_pkg::S_WDIV;
            end
            rbvs_pkg::S_DIVY: begin
                o_cmd.op = rbvs_pkg::OP_DIVY;
                n_wop    = rbvs_pkg::OP_AY;
                n_ret    = rbvs_pkg::S_FM;
                n_state  = rbvs_pkg::S_WDIV;
            end
            rbvs_pkg::S_WDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.op = r_wop;
                    n_state  = r_ret;
                end
            end
            rbvs_pkg::S_FM: begin
                o_cmd.op = rbvs_pkg::OP_FM;
                n_state  = rbvs_pkg::S_LSA;
            end
            rbvs_pkg::S_LSA: begin
                o_cmd.op = rbvs_pkg::OP_LSA;
                n_state  = rbvs_pkg::S_LSB;
            end
            rbvs_pkg::S_LSB: begin
                o_cmd.op = rbvs_pkg::OP_LSB;
                n_state  = (i_stat.mode == rbvs_pkg::MODE_BELT) ? rbvs_pkg::S_H
                                                                : rbvs_pkg::S_VX;
            end
            // Top-view vector sequence
            rbvs_pkg::S_VX: begin
                o_cmd.op = rbvs_pkg::OP_VX;
                n_state  = rbvs_pkg::S_VY;
            end
            rbvs_pkg::S_VY: begin
                o_cmd.op = rbvs_pkg::OP_VY;
                n_state  = rbvs_pkg::S_MOV0;
            end
            rbvs_pkg::S_MOV0: begin
                o_cmd.op = rbvs_pkg::OP_MOV0;
                n_ret    = rbvs_pkg::S_KCHK;
                n_state  = rbvs_pkg::S_SQX;
            end
            rbvs_pkg::S_SQX: begin
                o_cmd.op = rbvs_pkg::OP_SQX;
                n_state  = rbvs_pkg::S_SQY;
            end
            rbvs_pkg::S_SQY: begin
                o_cmd.op = rbvs_pkg::OP_SQY;
                n_state  = rbvs_pkg::S_WSQ;
            end
            rbvs_pkg::S_WSQ: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.op = rbvs_pkg::OP_LEN;
                    n_state  = r_ret;
                end
            end
            rbvs_pkg::S_KCHK: begin
                n_state = i_stat.kick_ok ? rbvs_pkg::S_KSET : rbvs_pkg::S_LEN2;
            end
            rbvs_pkg::S_KSET: begin
                o_cmd.op = rbvs_pkg::OP_KSET;
                n_kick   = 1'b1;
                n_sret   = rbvs_pkg::S_LEN2;
                n_state  = rbvs_pkg::S_SCX;
            end
            rbvs_pkg::S_SCX: begin
                o_cmd.op = rbvs_pkg::OP_DIVSX;
                n_wop    = r_kick ? rbvs_pkg::OP_KX : rbvs_pkg::OP_SX;
                n_ret    = rbvs_pkg::S_SCY;
                n_state  = rbvs_pkg::S_WDIV;
            end
            rbvs_pkg::S_SCY: begin
                o_cmd.op = rbvs_pkg::OP_DIVSY;
                n_wop    = r_kick ? rbvs_pkg::OP_KY : rbvs_pkg::OP_SY;
                n_ret    = r_sret;
                n_state  = rbvs_pkg::S_WDIV;
            end
            rbvs_pkg::S_LEN2: begin
                n_ret   = rbvs_pkg::S_FCHK;
                n_state = rbvs_pkg::S_SQX;
            end
            rbvs_pkg::S_FCHK: begin
                n_state = i_stat.len_nz ? rbvs_pkg::S_FSET : rbvs_pkg::S_LEN3;
            end
            rbvs_pkg::S_FSET: begin
                o_cmd.op = rbvs_pkg::OP_FSET;
                n_kick   = 1'b0;
                n_sret   = rbvs_pkg::S_LEN3;
                n_state  = rbvs_pkg::S_SCX;
            end
            rbvs_pkg::S_LEN3: begin
                n_ret   = rbvs_pkg::S_CCHK;
                n_state = rbvs_pkg::S_SQX;
            end
            rbvs_pkg::S_CCHK: begin
                n_state = i_stat.over_max ? rbvs_pkg::S_CSET : rbvs_pkg::S_COM0;
            end
            rbvs_pkg::S_CSET: begin
                o_cmd.op = rbvs_pkg::OP_CSET;
                n_kick   = 1'b0;
                n_sret   = rbvs_pkg::S_COM0;
                n_state  = rbvs_pkg::S_SCX;
            end
            rbvs_pkg::S_COM0: begin
                o_cmd.op = rbvs_pkg::OP_COM0;
                n_state  = rbvs_pkg::S_PX;
            end
            // Belt-scroll sequence
            rbvs_pkg::S_H: begin
                o_cmd.op = rbvs_pkg::OP_H;
                n_state  = rbvs_pkg::S_V;
            end
            rbvs_pkg::S_V: begin
                o_cmd.op = rbvs_pkg::OP_V;
                n_state  = rbvs_pkg::S_MOV1;
            end
            rbvs_pkg::S_MOV1: begin
                o_cmd.op = rbvs_pkg::OP_MOV1;
                n_state  = rbvs_pkg::S_KB;
            end
            rbvs_pkg::S_KB: begin
                o_cmd.op = rbvs_pkg::OP_KB;
                n_state  = rbvs_pkg::S_FRB;
            end
            rbvs_pkg::S_FRB: begin
                o_cmd.op = rbvs_pkg::OP_FRB;
                n_state  = rbvs_pkg::S_GRAV;
            end
            rbvs_pkg::S_GRAV: begin
                o_cmd.op = rbvs_pkg::OP_GRAV;
                n_state  = rbvs_pkg::S_COM1;
            end
            rbvs_pkg::S_COM1: begin
                o_cmd.op = rbvs_pkg::OP_COM1;
                n_state  = rbvs_pkg::S_PX;
            end
            // Position update and hand-over to the output register
            rbvs_pkg::S_PX: begin
                o_cmd.op = rbvs_pkg::OP_PX;
                n_state  = rbvs_pkg::S_PY;
            end
            rbvs_pkg::S_PY: begin
                o_cmd.op = rbvs_pkg::OP_PY;
                n_state  = rbvs_pkg::S_OUT;
            end
            rbvs_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = rbvs_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = rbvs_pkg::S_IDLE;
                end
            end
            default: n_state = rbvs_pkg::S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/rigid_body_velocity_step.sv
// Rigid-body velocity step: one result item per input item, handled one at a time, so no
// new item is taken before the last one is finished. In top-view mode the time an item takes
// depends on whether the start kick, friction and the speed cap need rescaling of the
// velocity vector. The time is set by the shared restoring divider, which produces one
// quotient bit per cycle (two divisions for the acceleration and two per vector rescale),
// and by the square-root unit, one root bit per cycle (three vector lengths in top-view
// mode). The finished item waits in an output register, so the next item is taken while it
// is still unread. The user must write the configuration registers through the plain write
// port only while the block is idle; the block itself does not enforce it.
module rigid_body_velocity_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rbvs_pkg::t_in  i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rbvs_pkg::t_out o_out_item
);

    rbvs_pkg::t_cfg  r_cfg;
    rbvs_pkg::t_cmd  w_cmd;
    rbvs_pkg::t_stat w_stat;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode          <= rbvs_pkg::MODE_TOP;
            r_cfg.mass          <= 31'd65536;
            r_cfg.initial_speed <= 31'd0;
            r_cfg.max_speed     <= 31'd65536000;
            r_cfg.friction      <= 31'd6553600;
            r_cfg.gravity       <= 32'sd64225280;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rbvs_pkg::CFG_MODE:     r_cfg.mode          <= i_cfg_data[0];
                rbvs_pkg::CFG_MASS:     r_cfg.mass          <= i_cfg_data[30:0];
                rbvs_pkg::CFG_INIT_SPD: r_cfg.initial_speed <= i_cfg_data[30:0];
                rbvs_pkg::CFG_MAX_SPD:  r_cfg.max_speed     <= i_cfg_data[30:0];
                rbvs_pkg::CFG_FRICTION: r_cfg.friction      <= i_cfg_data[30:0];
                rbvs_pkg::CFG_GRAVITY:  r_cfg.gravity       <= i_cfg_data;
                default:                r_cfg               <= r_cfg;
            endcase
        end
    end

    rbvs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    rbvs_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cfg      (r_cfg),
        .i_in_item  (i_in_item),
        .o_stat     (w_stat),
        .o_out_item (o_out_item)
    );

endmodule

### rtl/rbvs_checker.sv
module rbvs_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input rbvs_pkg::t_out o_out_item
);

    // A result item stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item withdrawn before it was taken");

    // A stalled result item keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("stalled result item changed");

    // One item is worked on at a time: no accept in the cycle after an accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again straight after an accept");

    // No result item appears straight after an input item is taken.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result item offered without any work done");

    // Reset leaves no result item pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item pending after reset");

endmodule

bind rigid_body_velocity_step rbvs_checker u_rbvs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
